// ===== rtl/core/call_frame_stack_manager_defines.svh =====
// ----------------------------------------------------------------------------
// Call frame stack manager assertion macros
// Clocked assertion wrappers used by the RTL datapath, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef CALL_FRAME_STACK_MANAGER_DEFINES_SVH
`define CALL_FRAME_STACK_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// assertion sampled on the rising clock edge, switched off during reset
`define CFSM_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on the rising clock edge, live during reset too
`define CFSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CFSM_ASSERT_RST(lbl, clk, rst, prop, msg)
`define CFSM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/cfsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Call frame stack manager package
// Sizes, codes, record layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cfsm_pkg;

   localparam int MAX_SLOTS  = 4096;
   localparam int MAX_FRAMES = 64;
   localparam int ADDR_BITS  = 32;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 12;
   localparam int CFG_W    = 13;
   localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = CFG_W'(1024);

   // derived widths
   localparam int SLOT_W  = $clog2(MAX_SLOTS);       // top / base index
   localparam int LIM_W   = SLOT_W + 1;              // limit and sums
   localparam int DEPTH_W = $clog2(MAX_FRAMES + 1);  // active frame count
   localparam int IDX_W   = $clog2(MAX_FRAMES);      // record memory index

   typedef enum logic [OP_W-1:0] {
      OP_ENTER   = 2'd0,
      OP_LEAVE   = 2'd1,
      OP_RESERVE = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_SLOT_OVF = 2'd1,
      ST_REC_FULL = 2'd2,
      ST_INVALID  = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]    ftop;
      logic [SLOT_W-1:0]    pbase;
      logic [ADDR_BITS-1:0] ret;
   } record_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic commit;    // apply the request and load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_full;  // result register holds an untaken transaction
   } sts_type;

endpackage

// ===== rtl/core/cfsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Call frame stack manager controller
// Two-state sequencer: accept a request, then commit it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
module cfsm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             rsp_stall,
   input  cfsm_pkg::sts_type sts,
   output cfsm_pkg::cmd_type cmd
);
   import cfsm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      can_commit;

   assign can_commit = !(sts.out_full && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (can_commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            cmd.commit = can_commit;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/cfsm_dpath.sv =====
`timescale 1ns / 1ps
`include "call_frame_stack_manager_defines.svh"
// ----------------------------------------------------------------------------
// Call frame stack manager datapath
// Top/base/depth registers, frame record memory, slot_count register and the
// result register.
// ----------------------------------------------------------------------------
module cfsm_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  cfsm_pkg::cmd_type                cmd,
   output cfsm_pkg::sts_type                sts,
   input  logic [cfsm_pkg::OP_W-1:0]        req_opcode,
   input  logic [cfsm_pkg::COUNT_W-1:0]     req_count,
   input  logic [cfsm_pkg::ADDR_BITS-1:0]   req_return_addr,
   input  logic                             csr_wr,
   input  logic [cfsm_pkg::CFG_W-1:0]       csr_data,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [cfsm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cfsm_pkg::SLOT_W-1:0]      rsp_top_index,
   output logic [cfsm_pkg::SLOT_W-1:0]      rsp_base_index,
   output logic [cfsm_pkg::ADDR_BITS-1:0]   rsp_popped_return,
   output logic [cfsm_pkg::DEPTH_W-1:0]     rsp_depth
);
   import cfsm_pkg::*;

   // architectural state
   logic [SLOT_W-1:0]  top_ff,   top_in;
   logic [SLOT_W-1:0]  base_ff,  base_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CFG_W-1:0]   slot_count_ff;
   logic [LIM_W-1:0]   slot_limit;

   // captured request
   op_type               op_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [ADDR_BITS-1:0] ret_ff;

   // record memory
   record_type mem [MAX_FRAMES];
   record_type rd_ff;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic             wr_en;
   record_type       wr_rec;

   // result register
   logic                 out_valid_ff;
   status_type           status_ff, status_in;
   logic [ADDR_BITS-1:0] popped_ff, popped_in;
   logic [SLOT_W-1:0]    rsp_top_ff, rsp_base_ff;
   logic [DEPTH_W-1:0]   rsp_depth_ff;

   // arithmetic
   logic [LIM_W-1:0]  top_ext;
   logic [LIM_W-1:0]  sum;
   logic [LIM_W-1:0]  top_p1;
   logic [SLOT_W-1:0] ftop;
   logic [LIM_W-1:0]  rel_need;
   logic              has_frame;

   // limit: slot_count saturated into [2, MAX_SLOTS]
   always_comb begin
      if (LIM_W'(slot_count_ff) < LIM_W'(2)) begin
         slot_limit = LIM_W'(2);
      end else if (LIM_W'(slot_count_ff) > LIM_W'(MAX_SLOTS)) begin
         slot_limit = LIM_W'(MAX_SLOTS);
      end else begin
         slot_limit = LIM_W'(slot_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
      end else begin
         if (csr_wr) begin
            slot_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_opcode);
         count_ff <= req_count;
         ret_ff   <= req_return_addr;
      end
   end

   // newest record is read every cycle; it is stable by the commit cycle
   assign rd_idx = IDX_W'(depth_ff - DEPTH_W'(1));
   assign wr_idx = depth_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_rec;
      end
      rd_ff <= mem[rd_idx];
   end

   assign has_frame = (depth_ff != '0);
   assign top_ext   = {1'b0, top_ff};
   assign sum       = top_ext + LIM_W'(count_ff);
   assign top_p1    = top_ext + LIM_W'(1);
   assign ftop      = has_frame ? rd_ff.ftop : '0;
   assign rel_need  = {1'b0, ftop} + LIM_W'(count_ff);

   always_comb begin
      top_in    = top_ff;
      base_in   = base_ff;
      depth_in  = depth_ff;
      status_in = ST_OK;
      popped_in = '0;
      wr_en     = 1'b0;
      wr_rec    = '{ftop: sum[SLOT_W-1:0], pbase: base_ff, ret: ret_ff};
      case (op_ff)
         OP_ENTER: begin
            if (sum >= slot_limit || top_p1 >= slot_limit) begin
               status_in = ST_SLOT_OVF;
            end else if (depth_ff >= DEPTH_W'(MAX_FRAMES)) begin
               status_in = ST_REC_FULL;
            end else begin
               wr_en    = cmd.commit;
               depth_in = depth_ff + DEPTH_W'(1);
               base_in  = top_p1[SLOT_W-1:0];
               top_in   = sum[SLOT_W-1:0];
            end
         end
         OP_LEAVE: begin
            if (!has_frame) begin
               status_in = ST_INVALID;
            end else begin
               depth_in  = depth_ff - DEPTH_W'(1);
               popped_in = rd_ff.ret;
               top_in    = (base_ff != '0) ? base_ff - SLOT_W'(1) : '0;
               base_in   = rd_ff.pbase;
            end
         end
         OP_RESERVE: begin
            if (sum >= slot_limit) begin
               status_in = ST_SLOT_OVF;
            end else begin
               top_in = sum[SLOT_W-1:0];
            end
         end
         OP_RELEASE: begin
            if (top_ext < rel_need) begin
               status_in = ST_INVALID;
            end else begin
               top_in = top_ff - SLOT_W'(count_ff);
            end
         end
         default: begin
            status_in = ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         base_ff  <= '0;
         depth_ff <= '0;
      end else if (cmd.commit) begin
         top_ff   <= top_in;
         base_ff  <= base_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         rsp_top_ff   <= top_in;
         rsp_base_ff  <= base_in;
         rsp_depth_ff <= depth_in;
      end
   end

   assign sts.out_full      = out_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_top_index     = rsp_top_ff;
   assign rsp_base_index    = rsp_base_ff;
   assign rsp_popped_return = popped_ff;
   assign rsp_depth         = rsp_depth_ff;

   // a failed request leaves top, base and depth untouched
   `CFSM_ASSERT_RST(a_fail_no_change, clock, reset,
      (cmd.commit && status_in != ST_OK) |=>
         (top_ff == $past(top_ff) && base_ff == $past(base_ff) &&
          depth_ff == $past(depth_ff)),
      "failed request changed state")

   // a granted enter or reserve keeps top below the limit
   `CFSM_ASSERT_RST(a_top_in_range, clock, reset,
      (cmd.commit && status_in == ST_OK && (op_ff == OP_ENTER || op_ff == OP_RESERVE)) |=>
         ({1'b0, top_ff} < $past(slot_limit)),
      "top reached the slot limit")

   // a granted leave drops one frame and reports its restored depth
   `CFSM_ASSERT_RST(a_leave_pops, clock, reset,
      (cmd.commit && status_in == ST_OK && op_ff == OP_LEAVE) |=>
         (DEPTH_W'(depth_ff + DEPTH_W'(1)) == $past(depth_ff) && rsp_depth == depth_ff),
      "leave did not pop one frame")

   // a new result only appears after a commit
   `CFSM_ASSERT_RST(a_rsp_from_commit, clock, reset,
      $rose(out_valid_ff) |-> $past(cmd.commit),
      "result without commit")

endmodule

// ===== rtl/core/call_frame_stack_manager.sv =====
`timescale 1ns / 1ps
// Usage: a request transaction on req_* (opcode: enter, leave, reserve or
// release, with count and return address) is taken when req_valid is high
// and req_stall is low. Each request returns exactly one result transaction
// on rsp_* (status, top index, base index, popped return address, depth),
// taken when rsp_valid is high and rsp_stall is low.
// An accepted request is captured, then commits from the execute state to
// the result register behind rsp_valid; the next request waits for that
// commit. The newest frame's record memory read is registered before it.
// A finished result waits in an output register, so the next request is
// accepted while it waits; a second result commits only once the first is
// taken, and req_stall stays high meanwhile.
// slot_count is written on csr_* (always ready), applies from the next
// request, and is meant to change only while no request is outstanding.
// Reset (synchronous) clears top, base and depth, sets slot_count to 1024
// and drops any pending result. The record memory is not cleared: only
// entries below the depth are ever used.
// ----------------------------------------------------------------------------
// Call frame stack manager
// Frame pointer and bounded record stack manager with status per request.
// ----------------------------------------------------------------------------
module call_frame_stack_manager (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cfsm_pkg::OP_W-1:0]        req_opcode,
   input  logic [cfsm_pkg::COUNT_W-1:0]     req_count,
   input  logic [cfsm_pkg::ADDR_BITS-1:0]   req_return_addr,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cfsm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cfsm_pkg::SLOT_W-1:0]      rsp_top_index,
   output logic [cfsm_pkg::SLOT_W-1:0]      rsp_base_index,
   output logic [cfsm_pkg::ADDR_BITS-1:0]   rsp_popped_return,
   output logic [cfsm_pkg::DEPTH_W-1:0]     rsp_depth,
   // slot_count register write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfsm_pkg::CFG_W-1:0]       csr_data
);
   import cfsm_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;

   // register write is never held off
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // sequencer: idle/accept, then commit when the result register is free or being taken
   cfsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // state registers, record memory and result register
   cfsm_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_count         (req_count),
      .req_return_addr   (req_return_addr),
      .csr_wr            (csr_wr),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_top_index     (rsp_top_index),
      .rsp_base_index    (rsp_base_index),
      .rsp_popped_return (rsp_popped_return),
      .rsp_depth         (rsp_depth)
   );

endmodule
